### hw/rtl/pwe_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the pid controller with error wrap
package pwe_pkg;

	// configuration register index
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_ON   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_LOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_HIGH = 3'd6;

	// reset values of the wrap bounds, truncated to the data width where used
	localparam logic signed [63:0] WRAP_LOW_RST  = -64'sd205887;
	localparam logic signed [63:0] WRAP_HIGH_RST = 64'sd205887;

	// multiplier digit width, bits of the second operand taken per cycle
	localparam int MUL_DIGIT_W = 8;

	typedef struct packed {
		logic busy;
		logic done;
	} pwe_unit_stat_t;

endpackage

### hw/rtl/pwe_if.sv
`timescale 1ns / 1ps
// channel interfaces for measurement, drive and configuration
interface pwe_meas_if #(
	parameter int DATA_WIDTH = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] measured_value;

	modport source (output valid, output measured_value, input ready);
	modport sink (input valid, input measured_value, output ready);
endinterface

interface pwe_drive_if #(
	parameter int DATA_WIDTH = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] drive_value;

	modport source (output valid, output drive_value, input ready);
	modport sink (input valid, input drive_value, output ready);
endinterface

interface pwe_cfg_if #(
	parameter int DATA_WIDTH = 32
) ();
	logic                            valid;
	logic                            ready;
	logic [pwe_pkg::CFG_IDX_W-1:0]   index;
	logic [DATA_WIDTH-1:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pid_with_error_wrap_unit.sv
`timescale 1ns / 1ps
// pid controller top level: sequencer over a shared multiplier and remainder unit
// one measurement at a time; the remainder unit runs only when wrapping is on
// and the range is not empty (remainder unit: DATA_WIDTH+2 one-bit steps)
// the three products run one after another on the one multiplier
// next request taken the cycle after the drive is loaded
// arst_n clears the configuration registers, integrator and last measurement; wrap bounds reset to +-205887
module pid_with_error_wrap_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	pwe_meas_if.sink    measure,
	pwe_drive_if.source drive,
	pwe_cfg_if.sink     cfg
);
	import pwe_pkg::*;

	localparam int W = DATA_WIDTH;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_STI  = 4'd3;
	localparam logic [3:0] S_WI   = 4'd4;
	localparam logic [3:0] S_STP  = 4'd5;
	localparam logic [3:0] S_WP   = 4'd6;
	localparam logic [3:0] S_STD  = 4'd7;
	localparam logic [3:0] S_WD   = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	localparam logic signed [W+1:0] SAT_MAX = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] SAT_MIN = {3'b111, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
		logic signed [W+1:0] c;
		c = v;
		if (v > SAT_MAX) c = SAT_MAX;
		if (v < SAT_MIN) c = SAT_MIN;
		return c[W-1:0];
	endfunction

	logic signed [W-1:0] gain_p, gain_i, gain_d, target, wrap_low, wrap_high;
	logic                wrap_on;

	logic [3:0]          state_q;
	logic signed [W:0]   err_q, dmeas_q;
	logic signed [W-1:0] prev_q, integ_q, p_q, d_q, total_q, drive_q;
	logic                wrap_go_q, drive_valid_q;

	logic                div_start, mul_start, in_acc, out_fire;
	pwe_unit_stat_t      div_stat, mul_stat;
	logic [W-1:0]        div_rem, wrap_span_w;
	logic signed [W:0]   err_n, dmeas_n, wrap_span, fold_err;
	logic signed [W+1:0] wrap_x, integ_sum, total_sum;
	logic signed [W:0]   mul_a;
	logic signed [W-1:0] mul_b, mul_res;

	pwe_regs #(.DATA_WIDTH(W)) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (cfg.valid),
		.index     (cfg.index),
		.data      (cfg.data),
		.gain_p    (gain_p),
		.gain_i    (gain_i),
		.gain_d    (gain_d),
		.target    (target),
		.wrap_on   (wrap_on),
		.wrap_low  (wrap_low),
		.wrap_high (wrap_high)
	);

	assign cfg.ready     = 1'b1;
	assign measure.ready = (state_q == S_IDLE);
	assign in_acc        = measure.valid && (state_q == S_IDLE);
	assign out_fire      = (state_q == S_OUT) && (!drive_valid_q || drive.ready);

	assign err_n   = {target[W-1], target} - {measure.measured_value[W-1], measure.measured_value};
	assign dmeas_n = {prev_q[W-1], prev_q} - {measure.measured_value[W-1], measure.measured_value};

	// width of the wrap range is positive when used, fits W bits unsigned
	assign wrap_span   = {wrap_high[W-1], wrap_high} - {wrap_low[W-1], wrap_low};
	assign wrap_span_w = wrap_span[W-1:0];
	assign wrap_x      = {err_q[W], err_q} - {{2{wrap_low[W-1]}}, wrap_low};
	assign fold_err    = $signed({1'b0, div_rem}) + {wrap_low[W-1], wrap_low};

	assign integ_sum = {{2{integ_q[W-1]}}, integ_q} + {{2{mul_res[W-1]}}, mul_res};
	assign total_sum = {{2{p_q[W-1]}}, p_q} + {{2{integ_q[W-1]}}, integ_q}
		+ {{2{d_q[W-1]}}, d_q};

	assign div_start = (state_q == S_PREP) && wrap_go_q;
	assign mul_start = (state_q == S_STI) || (state_q == S_STP) || (state_q == S_STD);

	always_comb begin
		mul_a = err_q;
		mul_b = gain_d;
		unique case (state_q)
			S_STI: mul_b = gain_i;
			S_STP: mul_b = gain_p;
			S_STD: mul_a = dmeas_q;
			default: ;
		endcase
	end

	pwe_div #(.DATA_WIDTH(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (wrap_x),
		.divisor   (wrap_span_w),
		.stat      (div_stat),
		.rem_floor (div_rem)
	);

	pwe_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.result (mul_res)
	);

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			drive_valid_q <= 1'b0;
			integ_q       <= '0;
			prev_q        <= '0;
			wrap_go_q     <= 1'b0;
		end else begin
			if (out_fire) begin
				drive_valid_q <= 1'b1;
			end else if (drive.ready) begin
				drive_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						prev_q    <= measure.measured_value;
						wrap_go_q <= wrap_on && (wrap_high > wrap_low);
						state_q   <= S_PREP;
					end
				end
				S_PREP: state_q <= wrap_go_q ? S_DIV : S_STI;
				S_DIV: begin
					if (div_stat.done) state_q <= S_STI;
				end
				S_STI: state_q <= S_WI;
				S_WI: begin
					if (mul_stat.done) begin
						integ_q <= sat_w(integ_sum);
						state_q <= S_STP;
					end
				end
				S_STP: state_q <= S_WP;
				S_WP: begin
					if (mul_stat.done) state_q <= S_STD;
				end
				S_STD: state_q <= S_WD;
				S_WD: begin
					if (mul_stat.done) state_q <= S_SUM;
				end
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q   <= err_n;
			dmeas_q <= dmeas_n;
		end
		if (state_q == S_DIV && div_stat.done) begin
			err_q <= fold_err;
		end
		if (state_q == S_WP && mul_stat.done) begin
			p_q <= mul_res;
		end
		if (state_q == S_WD && mul_stat.done) begin
			d_q <= mul_res;
		end
		if (state_q == S_SUM) begin
			total_q <= sat_w(total_sum);
		end
		if (out_fire) begin
			drive_q <= total_q;
		end
	end

	assign drive.valid       = drive_valid_q;
	assign drive.drive_value = drive_q;

endmodule

### hw/rtl/pwe_regs.sv
`timescale 1ns / 1ps
// configuration register file
module pwe_regs #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [pwe_pkg::CFG_IDX_W-1:0]   index,
	input  logic [DATA_WIDTH-1:0]           data,
	output logic signed [DATA_WIDTH-1:0]    gain_p,
	output logic signed [DATA_WIDTH-1:0]    gain_i,
	output logic signed [DATA_WIDTH-1:0]    gain_d,
	output logic signed [DATA_WIDTH-1:0]    target,
	output logic                            wrap_on,
	output logic signed [DATA_WIDTH-1:0]    wrap_low,
	output logic signed [DATA_WIDTH-1:0]    wrap_high
);
	import pwe_pkg::*;

	logic signed [DATA_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q, target_q;
	logic signed [DATA_WIDTH-1:0] wrap_low_q, wrap_high_q;
	logic                         wrap_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			target_q    <= '0;
			wrap_on_q   <= 1'b0;
			wrap_low_q  <= WRAP_LOW_RST[DATA_WIDTH-1:0];
			wrap_high_q <= WRAP_HIGH_RST[DATA_WIDTH-1:0];
		end else if (we) begin
			unique case (index)
				REG_GAIN_P:    gain_p_q    <= data;
				REG_GAIN_I:    gain_i_q    <= data;
				REG_GAIN_D:    gain_d_q    <= data;
				REG_TARGET:    target_q    <= data;
				REG_WRAP_ON:   wrap_on_q   <= data[0];
				REG_WRAP_LOW:  wrap_low_q  <= data;
				REG_WRAP_HIGH: wrap_high_q <= data;
				default: ;
			endcase
		end
	end

	assign gain_p    = gain_p_q;
	assign gain_i    = gain_i_q;
	assign gain_d    = gain_d_q;
	assign target    = target_q;
	assign wrap_on   = wrap_on_q;
	assign wrap_low  = wrap_low_q;
	assign wrap_high = wrap_high_q;

endmodule

### hw/rtl/pwe_div.sv
`timescale 1ns / 1ps
// bit-serial floored remainder unit for the error wrap
module pwe_div #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [DATA_WIDTH+1:0]   dividend,
	input  logic [DATA_WIDTH-1:0]          divisor,
	output pwe_pkg::pwe_unit_stat_t        stat,
	output logic [DATA_WIDTH-1:0]          rem_floor
);
	import pwe_pkg::*;

	localparam int STEPS = DATA_WIDTH + 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic                  busy_q, fin_q, done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH+1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dsr_q, rem_q, res_q;
	logic                  neg_q;

	logic [DATA_WIDTH+1:0] dvd_mag;
	logic [DATA_WIDTH:0]   trial, trial_sub;

	assign dvd_mag   = dividend[DATA_WIDTH+1] ? (~dividend + 1'b1) : dividend;
	assign trial     = {rem_q, dvd_q[DATA_WIDTH+1]};
	assign trial_sub = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd_mag;
			dsr_q <= divisor;
			neg_q <= dividend[DATA_WIDTH+1];
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_WIDTH:0], 1'b0};
			// restoring step, remainder stays below the divisor
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial_sub[DATA_WIDTH-1:0];
			end else begin
				rem_q <= trial[DATA_WIDTH-1:0];
			end
		end
		if (fin_q) begin
			// floor toward minus infinity for a negative dividend
			res_q <= (neg_q && rem_q != '0) ? (dsr_q - rem_q) : rem_q;
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;
	assign rem_floor = res_q;

endmodule

### hw/rtl/pwe_mul.sv
`timescale 1ns / 1ps
// digit-serial fixed-point multiplier with floor shift and saturation
module pwe_mul #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [DATA_WIDTH:0]    a,
	input  logic signed [DATA_WIDTH-1:0]  b,
	output pwe_pkg::pwe_unit_stat_t       stat,
	output logic signed [DATA_WIDTH-1:0]  result
);
	import pwe_pkg::*;

	localparam int NCH   = (DATA_WIDTH + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
	localparam int BP    = NCH * MUL_DIGIT_W;
	localparam int PW    = DATA_WIDTH + 1 + BP;
	localparam int QW    = ((PW - FRAC_BITS) > DATA_WIDTH ? (PW - FRAC_BITS) : DATA_WIDTH) + 1;
	localparam int CNT_W = $clog2(NCH + 1);

	logic                          busy_q, fin_q, done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [DATA_WIDTH:0]           ua_q;
	logic [BP-1:0]                 ub_q;
	logic [PW-1:0]                 acc_q;
	logic                          neg_q;
	logic signed [DATA_WIDTH-1:0]  res_q;

	logic [DATA_WIDTH:0]             a_mag;
	logic [DATA_WIDTH-1:0]           b_mag;
	logic [DATA_WIDTH+MUL_DIGIT_W:0] part;
	logic [QW-1:0]                   q_inc, q_lim, q_sat;
	logic [DATA_WIDTH-1:0]           q_w;
	logic                            frac_nz;

	assign a_mag = a[DATA_WIDTH] ? (~a + 1'b1) : a;
	assign b_mag = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
	assign part  = ua_q * ub_q[BP-1 -: MUL_DIGIT_W];

	// floor of the shifted product: magnitude rounds up when negative and inexact
	assign frac_nz = acc_q[FRAC_BITS-1:0] != '0;
	assign q_inc   = QW'(acc_q[PW-1:FRAC_BITS]) + QW'(neg_q && frac_nz);
	assign q_lim   = neg_q ? (QW'(1) << (DATA_WIDTH - 1)) : ((QW'(1) << (DATA_WIDTH - 1)) - 1'b1);
	assign q_sat   = (q_inc > q_lim) ? q_lim : q_inc;
	assign q_w     = q_sat[DATA_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NCH - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a_mag;
			ub_q  <= BP'(b_mag);
			neg_q <= a[DATA_WIDTH] ^ b[DATA_WIDTH-1];
			acc_q <= '0;
		end else if (busy_q) begin
			// most significant digit first
			acc_q <= {acc_q[PW-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}} + PW'(part);
			ub_q  <= {ub_q[BP-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
		end
		if (fin_q) begin
			res_q <= neg_q ? (~q_w + 1'b1) : q_w;
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;
	assign result    = res_q;

endmodule

### hw/rtl/pwe_checker.sv
`timescale 1ns / 1ps
// port-level checks for the pid controller, bound to the top level
module pwe_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] out_data
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("drive result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in flight");

	// a new result only appears at the end of a request, never while idle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a request in flight");

	// result never rises in the cycle after a request is taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result produced in the cycle after acceptance");

endmodule

bind pid_with_error_wrap_unit pwe_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pwe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (measure.valid),
	.in_ready  (measure.ready),
	.out_valid (drive.valid),
	.out_ready (drive.ready),
	.out_data  (drive.drive_value)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for the pid controller with error wrap: directed and random measurements
module tb;
	import pwe_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam longint DW_MAX = 64'sd2147483647;
	localparam longint DW_MIN = -64'sd2147483648;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [DW-1:0] ONE_Q = 32'h0001_0000;
	localparam logic [DW-1:0] MAX_Q = 32'h7fff_ffff;
	localparam logic [DW-1:0] MIN_Q = 32'h8000_0000;
	localparam int SETTLE_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n;

	pwe_meas_if #(.DATA_WIDTH(DW)) meas_bus ();
	pwe_drive_if #(.DATA_WIDTH(DW)) drive_bus ();
	pwe_cfg_if #(.DATA_WIDTH(DW)) cfg_bus ();

	pid_with_error_wrap_unit #(
		.DATA_WIDTH(DW),
		.FRAC_BITS(FB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.measure(meas_bus),
		.drive(drive_bus),
		.cfg(cfg_bus)
	);

	always #4 clk = ~clk;

	// shadow of the controller registers and state
	longint kp_q, ki_q, kd_q, target_q, wrap_lo_q, wrap_hi_q;
	bit wrap_en;
	longint integ_acc, last_meas;

	logic signed [DW-1:0] expected_drive[$];
	int fail_count = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;

	function automatic longint clamp_dw(input longint v);
		if (v > DW_MAX)
			return DW_MAX;
		if (v < DW_MIN)
			return DW_MIN;
		return v;
	endfunction

	// exact product, floor shift by the fraction bits, saturate
	function automatic longint mul_fix(input longint a, input longint b);
		logic signed [127:0] wa, wb, prod;
		wa = a;
		wb = b;
		prod = (wa * wb) >>> FB;
		if (prod > DW_MAX)
			return DW_MAX;
		if (prod < DW_MIN)
			return DW_MIN;
		return longint'(prod);
	endfunction

	function automatic logic signed [DW-1:0] predict_drive(input logic signed [DW-1:0] m);
		longint meas_l, err, dmeas, span, rem, pterm, dterm, total;
		meas_l = m;
		err = target_q - meas_l;
		dmeas = last_meas - meas_l;
		if (wrap_en && wrap_hi_q > wrap_lo_q) begin
			span = wrap_hi_q - wrap_lo_q;
			rem = (err - wrap_lo_q) % span;
			if (rem < 0)
				rem += span;
			err = rem + wrap_lo_q;
		end
		integ_acc = clamp_dw(integ_acc + mul_fix(err, ki_q));
		pterm = mul_fix(err, kp_q);
		dterm = mul_fix(dmeas, kd_q);
		total = clamp_dw(pterm + integ_acc + dterm);
		last_meas = meas_l;
		return total[DW-1:0];
	endfunction

	// output side: random back-pressure
	always @(negedge clk) begin
		drive_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		logic signed [DW-1:0] want;
		if (arst_n && drive_bus.valid && drive_bus.ready) begin
			if (expected_drive.size() == 0) begin
				$error("drive_value: no request pending, got %0d", drive_bus.drive_value);
				fail_count++;
			end else begin
				want = expected_drive.pop_front();
				if (drive_bus.drive_value !== want) begin
					$error("drive_value: expected %0d, got %0d", want,
						drive_bus.drive_value);
					fail_count++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance with valid
	// still high, so the caller follows with another request or with wait_idle
	task automatic send_measurement(input logic [DW-1:0] m);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			meas_bus.valid <= 1'b0;
			@(negedge clk);
		end
		meas_bus.valid <= 1'b1;
		meas_bus.measured_value <= m;
		@(posedge clk);
		while (!meas_bus.ready)
			@(posedge clk);
		expected_drive.push_back(predict_drive(m));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		meas_bus.valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			REG_GAIN_P: kp_q = longint'($signed(value));
			REG_GAIN_I: ki_q = longint'($signed(value));
			REG_GAIN_D: kd_q = longint'($signed(value));
			REG_TARGET: target_q = longint'($signed(value));
			REG_WRAP_ON: wrap_en = value[0];
			REG_WRAP_LOW: wrap_lo_q = longint'($signed(value));
			REG_WRAP_HIGH: wrap_hi_q = longint'($signed(value));
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_gains(input logic [DW-1:0] kp, input logic [DW-1:0] ki,
			input logic [DW-1:0] kd, input logic [DW-1:0] tgt);
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_TARGET, tgt);
	endtask

	function automatic logic [DW-1:0] pick_gain();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return $urandom;
			1: return '0;
			2: return ($urandom_range(0, 1) != 0) ? MAX_Q : MIN_Q;
			3: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
			default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
		endcase
	endfunction

	task automatic program_random_setting();
		logic [DW-1:0] lo, hi, tgt;
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				lo = $urandom;
				hi = $urandom;
			end
			1: begin
				lo = MIN_Q;
				hi = MAX_Q;
			end
			2: begin
				lo = $urandom;
				hi = lo;
			end
			3: begin
				lo = $urandom;
				hi = lo + 32'($urandom_range(1, 1 << 20));
			end
			default: begin
				hi = 32'($urandom_range(1, 1 << 20));
				lo = -hi;
			end
		endcase
		tgt = ($urandom_range(0, 3) == 0) ? $urandom :
			32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		load_gains(pick_gain(), pick_gain(), pick_gain(), tgt);
		write_reg(REG_WRAP_ON, {$urandom} & ~32'h1 | 32'($urandom_range(0, 2) != 0));
		write_reg(REG_WRAP_LOW, lo);
		write_reg(REG_WRAP_HIGH, hi);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, $urandom);
	endtask

	task automatic test_reset_values();
		send_measurement(32'h0012_3456);
		send_measurement(MIN_Q);
		wait_idle();
		// reset wrap bounds of about +-pi take effect once folding is on
		write_reg(REG_WRAP_ON, 32'h1);
		write_reg(REG_GAIN_P, ONE_Q);
		send_measurement(32'h0008_0000);
		send_measurement(32'hfff0_0000);
		wait_idle();
	endtask

	task automatic test_unwrapped_extremes();
		write_reg(REG_WRAP_ON, 32'h0);
		load_gains(ONE_Q, 32'h0, 32'h0, 32'h0);
		send_measurement(MIN_Q);
		send_measurement(MAX_Q);
		send_measurement(32'h0);
		send_measurement(32'hffff_ffff);
		wait_idle();
	endtask

	task automatic test_full_scale_gains();
		load_gains(MIN_Q, MAX_Q, MIN_Q, MAX_Q);
		send_measurement(MIN_Q);
		send_measurement(MAX_Q);
		send_measurement(MIN_Q);
		wait_idle();
	endtask

	task automatic test_wrap_folding();
		load_gains(ONE_Q, 32'h0000_1000, 32'h0000_0800, 32'h0);
		write_reg(REG_WRAP_ON, 32'h1);
		write_reg(REG_WRAP_LOW, -32'sd205887);
		write_reg(REG_WRAP_HIGH, 32'sd205887);
		// error on the lower bound stays, error on the upper bound folds to the lower one
		send_measurement(32'sd205887);
		send_measurement(-32'sd205887);
		send_measurement(MAX_Q);
		send_measurement(MIN_Q);
		wait_idle();
	endtask

	task automatic test_wrap_empty_range();
		write_reg(REG_WRAP_LOW, 32'h0001_0000);
		write_reg(REG_WRAP_HIGH, 32'h0001_0000);
		send_measurement(32'h0100_0000);
		send_measurement(MIN_Q);
		wait_idle();
		write_reg(REG_WRAP_HIGH, 32'hffff_0000);
		send_measurement(32'h0100_0000);
		send_measurement(MAX_Q);
		wait_idle();
	endtask

	task automatic test_spare_register();
		write_reg(REG_SPARE, 32'hdead_beef);
		// only bit 0 of the wrap enable counts
		write_reg(REG_WRAP_ON, 32'hffff_fffe);
		send_measurement(32'h0040_0000);
		send_measurement(32'hff80_0000);
		wait_idle();
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
		logic [DW-1:0] m;
		int sel;
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 140 == 0) begin
				wait_idle();
				program_random_setting();
			end
			sel = $urandom_range(0, 19);
			if (sel < 11)
				m = 32'(target_q) + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
			else if (sel < 15)
				m = 32'(last_meas) + 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
			else if (sel < 19)
				m = $urandom;
			else
				m = ($urandom_range(0, 1) != 0) ? MAX_Q : MIN_Q;
			send_measurement(m);
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		meas_bus.valid = 1'b0;
		meas_bus.measured_value = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		drive_bus.ready = 1'b0;
		kp_q = 0;
		ki_q = 0;
		kd_q = 0;
		target_q = 0;
		wrap_en = 1'b0;
		wrap_lo_q = WRAP_LOW_RST;
		wrap_hi_q = WRAP_HIGH_RST;
		integ_acc = 0;
		last_meas = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle_pct = 19;
		receiver_idle_pct = 72;
		test_reset_values();
		test_unwrapped_extremes();
		test_full_scale_gains();
		test_wrap_folding();
		test_wrap_empty_range();
		test_spare_register();

		test_random_phase(19, 72, 410);
		test_random_phase(72, 19, 410);
		test_random_phase(0, 0, 410);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_drive.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
